>>> hw/rtl/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared types and codes for the first-fit region table allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rtf_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;

	localparam logic [2:0] CMD_MAP     = 3'd0;
	localparam logic [2:0] CMD_REQUEST = 3'd1;
	localparam logic [2:0] CMD_RELEASE = 3'd2;
	localparam logic [2:0] CMD_UNMAP   = 3'd3;
	localparam logic [2:0] CMD_FIND    = 3'd4;
	localparam logic [2:0] CMD_READ    = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [3:0] KIND_EMPTY    = 4'd0;
	localparam logic [3:0] KIND_FREE     = 4'd1;
	localparam logic [3:0] KIND_RESERVED = 4'd2;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] length;
		logic [3:0]  kind;
	} entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/rtf_cell.sv
// ----------------------------------------------------------------------------
// rtf_cell
// One table slot of the rotating region ring.
// ----------------------------------------------------------------------------
`default_nettype none
module rtf_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire rtf_pkg::entry_t d,
	output rtf_pkg::entry_t      q
);

	rtf_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

>>> hw/rtl/region_table_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// region_table_first_fit_allocator_top
// First-fit region allocator built on a rotating ring of table slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command item; output channel
//   (out_valid/out_stall) returns exactly one result item per command.
//   The table is a ring of TABLE_ENTRIES cells that, during the scan and
//   apply passes, rotates one slot per cycle past a single head position
//   where all compares and edits happen. Each command takes one full
//   rotation to scan (first empty slot, first fitting free region, address
//   match, indexed entry), a decision state, one full rotation to apply
//   edits and capture the result slot, and a done state that loads the
//   output register once it is free; out_valid rises with that load. The
//   next command is taken only after the block has returned to idle.
//   in_stall is high while a command is in flight. A finished result sits in
//   the output register; a new command may be accepted while it waits, and
//   that command holds its result until the output register is taken.
//   Reset empties every slot and clears the live count; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module region_table_first_fit_allocator_top #(
	parameter int unsigned TABLE_ENTRIES = rtf_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] block_addr,
	input  wire logic [31:0] block_size,
	input  wire logic [3:0]  block_type,
	input  wire logic [5:0]  entry_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [5:0]       result_index,
	output logic [31:0]      result_addr,
	output logic [31:0]      result_size,
	output logic [3:0]       result_type,
	output logic [6:0]       live_count
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_APPLY, S_DONE} state_t;

	state_t state_q;
	logic [IW-1:0] cnt_q;
	logic [CW-1:0] used_q;

	logic [2:0]  cmd_q;
	logic [31:0] addr_q, size_q;
	logic [3:0]  type_q;
	logic [5:0]  idx_q;

	logic          e_found_q, fit_found_q, match_found_q;
	logic [IW-1:0] e_idx_q, fit_idx_q, match_idx_q;
	logic [31:0]   fit_base_q, fit_len_q;
	logic [3:0]    idx_kind_q;

	logic          do_new_q, do_upd_q, do_rel_q, do_unm_q;
	logic [IW-1:0] res_idx_q;
	logic [1:0]    res_st_q;
	rtf_pkg::entry_t res_ent_q;

	logic          out_valid_q;
	logic [1:0]    out_st_q;
	logic [5:0]    out_idx_q;
	logic [6:0]    out_live_q;
	rtf_pkg::entry_t out_ent_q;

	logic [1:0]    dec_st;
	logic [IW-1:0] dec_idx;
	logic          dec_new, dec_upd, dec_rel, dec_unm;
	logic [CW-1:0] dec_used;
	logic          out_load;

	rtf_pkg::entry_t ring [TABLE_ENTRIES];
	rtf_pkg::entry_t head, head_mod;
	logic shift;
	logic idx_ok, idx_hit;

	assign shift    = (state_q == S_SCAN) || (state_q == S_APPLY);
	assign head     = ring[0];
	assign idx_ok   = 32'(idx_q) < 32'(TABLE_ENTRIES);
	assign idx_hit  = idx_ok && (32'(cnt_q) == 32'(idx_q));
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		head_mod = head;
		if (state_q == S_APPLY) begin
			if (do_new_q && cnt_q == e_idx_q) begin
				head_mod.base   = (cmd_q == rtf_pkg::CMD_MAP) ? addr_q : fit_base_q;
				head_mod.length = size_q;
				head_mod.kind   = (cmd_q == rtf_pkg::CMD_MAP) ? type_q
				                                             : rtf_pkg::KIND_RESERVED;
			end else if (do_upd_q && cnt_q == fit_idx_q) begin
				head_mod.base   = fit_base_q + size_q;
				head_mod.length = fit_len_q - size_q;
			end else if (do_rel_q && idx_hit) begin
				head_mod.kind = rtf_pkg::KIND_FREE;
			end else if (do_unm_q && idx_hit) begin
				head_mod = '0;
			end
		end
	end

	always_comb begin
		dec_st   = rtf_pkg::ST_INVALID;
		dec_idx  = '0;
		dec_new  = 1'b0;
		dec_upd  = 1'b0;
		dec_rel  = 1'b0;
		dec_unm  = 1'b0;
		dec_used = used_q;
		unique case (cmd_q)
			rtf_pkg::CMD_MAP: begin
				if (size_q == '0 || type_q == rtf_pkg::KIND_EMPTY) begin
					dec_st = rtf_pkg::ST_INVALID;
				end else if (!e_found_q) begin
					dec_st = rtf_pkg::ST_FULL;
				end else begin
					dec_st   = rtf_pkg::ST_OK;
					dec_idx  = e_idx_q;
					dec_new  = 1'b1;
					dec_used = used_q + 1'b1;
				end
			end
			rtf_pkg::CMD_REQUEST: begin
				if (size_q == '0) begin
					dec_st = rtf_pkg::ST_INVALID;
				end else if (!fit_found_q || !e_found_q) begin
					dec_st = rtf_pkg::ST_FULL;
				end else begin
					dec_st   = rtf_pkg::ST_OK;
					dec_idx  = e_idx_q;
					dec_new  = 1'b1;
					dec_upd  = 1'b1;
					dec_used = used_q + 1'b1;
				end
			end
			rtf_pkg::CMD_RELEASE, rtf_pkg::CMD_UNMAP: begin
				if (!idx_ok || idx_kind_q == rtf_pkg::KIND_EMPTY) begin
					dec_st = rtf_pkg::ST_NOT_FOUND;
				end else begin
					dec_st  = rtf_pkg::ST_OK;
					dec_idx = IW'(idx_q);
					if (cmd_q == rtf_pkg::CMD_RELEASE) begin
						dec_rel = 1'b1;
					end else begin
						dec_unm = 1'b1;
						if (used_q != '0) begin
							dec_used = used_q - 1'b1;
						end
					end
				end
			end
			rtf_pkg::CMD_FIND: begin
				if (!match_found_q) begin
					dec_st = rtf_pkg::ST_NOT_FOUND;
				end else begin
					dec_st  = rtf_pkg::ST_OK;
					dec_idx = match_idx_q;
				end
			end
			rtf_pkg::CMD_READ: begin
				if (idx_ok) begin
					dec_st  = rtf_pkg::ST_OK;
					dec_idx = IW'(idx_q);
				end
			end
			default: begin
				dec_st = rtf_pkg::ST_INVALID;
			end
		endcase
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ring
		rtf_pkg::entry_t d;
		if (i == TABLE_ENTRIES - 1) begin : g_tail
			assign d = head_mod;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		rtf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			do_new_q    <= 1'b0;
			do_upd_q    <= 1'b0;
			do_rel_q    <= 1'b0;
			do_unm_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q         <= command;
						addr_q        <= block_addr;
						size_q        <= block_size;
						type_q        <= block_type;
						idx_q         <= entry_index;
						e_found_q     <= 1'b0;
						fit_found_q   <= 1'b0;
						match_found_q <= 1'b0;
						idx_kind_q    <= rtf_pkg::KIND_EMPTY;
						cnt_q         <= '0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!e_found_q && head.kind == rtf_pkg::KIND_EMPTY) begin
						e_found_q <= 1'b1;
						e_idx_q   <= cnt_q;
					end
					if (!fit_found_q && head.kind == rtf_pkg::KIND_FREE
					    && head.length >= size_q) begin
						fit_found_q <= 1'b1;
						fit_idx_q   <= cnt_q;
						fit_base_q  <= head.base;
						fit_len_q   <= head.length;
					end
					if (!match_found_q && head.kind != rtf_pkg::KIND_EMPTY
					    && head.base == addr_q) begin
						match_found_q <= 1'b1;
						match_idx_q   <= cnt_q;
					end
					if (idx_hit) begin
						idx_kind_q <= head.kind;
					end
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DECIDE: begin
					res_st_q  <= dec_st;
					res_idx_q <= dec_idx;
					do_new_q  <= dec_new;
					do_upd_q  <= dec_upd;
					do_rel_q  <= dec_rel;
					do_unm_q  <= dec_unm;
					used_q    <= dec_used;
					state_q   <= S_APPLY;
				end
				S_APPLY: begin
					if (cnt_q == res_idx_q) begin
						res_ent_q <= head_mod;
					end
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					do_new_q <= 1'b0;
					do_upd_q <= 1'b0;
					do_rel_q <= 1'b0;
					do_unm_q <= 1'b0;
					if (out_load) begin
						out_st_q   <= res_st_q;
						out_live_q <= 7'(used_q);
						if (res_st_q == rtf_pkg::ST_OK) begin
							out_idx_q <= 6'(res_idx_q);
							out_ent_q <= res_ent_q;
						end else begin
							out_idx_q <= '0;
							out_ent_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_st_q;
	assign result_index = out_idx_q;
	assign result_addr  = out_ent_q.base;
	assign result_size  = out_ent_q.length;
	assign result_type  = out_ent_q.kind;
	assign live_count   = out_live_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(TABLE_ENTRIES))
		else $error("live count above table size");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != rtf_pkg::ST_OK) |->
		(out_idx_q == '0 && out_ent_q == '0))
		else $error("error result carries slot data");

	a_scan_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cnt_q == LAST) |=> (state_q == S_DECIDE && cnt_q == '0))
		else $error("scan pass did not end after one rotation");

	a_edit_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !(do_new_q || do_upd_q || do_rel_q || do_unm_q))
		else $error("edit enabled during scan");

endmodule
`default_nettype wire
